// ===== src/array_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the array priority queue
// Shared wrappers for the concurrent checks in the queue RTL.
// ----------------------------------------------------------------------------
`ifndef ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define ARRAY_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define APQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define APQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// apq_pkg
// Types and codes shared by the array priority queue modules.
// ----------------------------------------------------------------------------
package apq_pkg;

   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 4;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

   // One stored entry
   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] pri;
   } entry_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT
   } state_type;

   // Control from the sequencer to the best-entry tracker
   typedef struct packed {
      logic vld;    // candidate entry present this cycle
      logic first;  // candidate is entry zero: load unconditionally
   } scan_ctl_type;

endpackage

// ===== src/apq_mem.sv =====
// ----------------------------------------------------------------------------
// apq_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module apq_mem #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  apq_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output apq_pkg::entry_type  rd_data
);
   import apq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/apq_best.sv =====
// ----------------------------------------------------------------------------
// apq_best
// Shared signed comparator and best-entry registers for the priority scan.
// ----------------------------------------------------------------------------
module apq_best #(
   parameter int IDX_W = 4
) (
   input  logic                   clock,
   input  apq_pkg::scan_ctl_type  ctl,
   input  logic [IDX_W-1:0]       cand_idx,
   input  apq_pkg::entry_type     cand,
   output logic [IDX_W-1:0]       best_idx_in,
   output logic signed [apq_pkg::DATA_W-1:0] best_val
);
   import apq_pkg::*;

   logic [IDX_W-1:0]         best_idx_ff;
   logic signed [DATA_W-1:0] best_pri_ff;
   logic signed [DATA_W-1:0] best_pri_in;
   logic signed [DATA_W-1:0] best_val_ff;
   logic signed [DATA_W-1:0] best_val_in;
   logic                     take;

   // Strictly greater wins, so the earliest entry keeps a tie
   assign take = ctl.vld && (ctl.first || (cand.pri > best_pri_ff));

   // Select the new leader
   always_comb begin
      best_idx_in = best_idx_ff;
      best_pri_in = best_pri_ff;
      best_val_in = best_val_ff;
      if (take) begin
         best_idx_in = cand_idx;
         best_pri_in = cand.pri;
         best_val_in = cand.val;
      end
   end

   // Hold the leader
   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_pri_ff <= best_pri_in;
      best_val_ff <= best_val_in;
   end

   assign best_val = best_val_ff;

endmodule

// ===== src/array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// array_priority_queue
// Bounded priority queue of QUEUE_DEPTH value and priority pairs, kept
// unsorted in arrival order. Raise start with an item while busy is low; every
// item gives exactly one result, shown for one cycle with rsp_valid high, and
// the receiver must take it then. Insert, clear, an unused op code, overflow
// and underflow give their result in the cycle after the item is taken. A
// remove on n entries reads every entry through the single read port of the
// entry memory into one comparator, then moves the later entries down one
// place through the same port. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "array_priority_queue_defines.svh"

module array_priority_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [apq_pkg::OP_W-1:0]            req_op,
   input  logic signed [apq_pkg::DATA_W-1:0]   req_value_in,
   input  logic signed [apq_pkg::DATA_W-1:0]   req_priority_in,
   output logic                                rsp_valid,
   output logic signed [apq_pkg::DATA_W-1:0]   rsp_value_out,
   output logic [apq_pkg::STAT_W-1:0]          rsp_status,
   output logic [apq_pkg::OCC_W-1:0]           rsp_occupancy
);
   import apq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [CW-1:0] rd_tag_ff, rd_tag_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [OCC_W-1:0]         rsp_occ_ff, rsp_occ_in;
   logic [CW+OCC_W-1:0]      occ_ext;

   logic      mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type mem_wdata;
   logic      mem_re;
   logic [AW-1:0] mem_raddr;
   entry_type mem_rdata;

   scan_ctl_type             scan_ctl;
   logic [CW-1:0]            best_idx_in;
   logic signed [DATA_W-1:0] best_val;

   logic accept;
   logic rd_more;
   logic scan_last;
   logic shift_done;

   apq_mem #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   apq_best #(
      .IDX_W (CW)
   ) u_best (
      .clock       (clock),
      .ctl         (scan_ctl),
      .cand_idx    (rd_tag_ff),
      .cand        (mem_rdata),
      .best_idx_in (best_idx_in),
      .best_val    (best_val)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign rd_more    = (rd_ptr_ff < count_ff);
   assign scan_last  = rd_vld_ff && (rd_tag_ff == (count_ff - CW'(1)));
   assign shift_done = !rd_more && !rd_vld_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_REMOVE) && (count_ff != '0)) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (shift_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath controls and next values
   always_comb begin
      count_in       = count_ff;
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_vld_in      = 1'b0;
      rd_tag_in      = rd_ptr_ff;
      mem_we         = 1'b0;
      mem_waddr      = count_ff[AW-1:0];
      mem_wdata.val  = req_value_in;
      mem_wdata.pri  = req_priority_in;
      mem_re         = 1'b0;
      mem_raddr      = rd_ptr_ff[AW-1:0];
      scan_ctl.vld   = 1'b0;
      scan_ctl.first = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_value_in   = '0;
      rsp_status_in  = ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_UNDERFLOW;
                     end else begin
                        rd_ptr_in = '0;
                     end
                  end
                  OP_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue the next read and compare the data that came back
            if (rd_more) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            scan_ctl.vld   = rd_vld_ff;
            scan_ctl.first = (rd_tag_ff == '0);
            if (scan_last) begin
               rd_ptr_in = best_idx_in + CW'(1);
               wr_ptr_in = best_idx_in;
            end
         end
         S_SHIFT: begin
            // Read one entry ahead, write it one place down
            if (rd_more) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr_ff[AW-1:0];
               mem_wdata = mem_rdata;
               wr_ptr_in = wr_ptr_ff + CW'(1);
            end
            if (shift_done) begin
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               rsp_value_in = best_val;
            end
         end
         default: begin
         end
      endcase
   end

   // Occupancy carries the low bits of the count
   assign occ_ext    = {{OCC_W{1'b0}}, count_in};
   assign rsp_occ_in = occ_ext[OCC_W-1:0];

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pointers and result payload
   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      rd_tag_ff     <= rd_tag_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // Checks
   `APQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= CW'(QUEUE_DEPTH), "count above depth")
   `APQ_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff,
      state_ff == S_IDLE, "result while busy")
   `APQ_ASSERT_NXT(a_quick_rsp, clock, reset,
      accept && ((req_op != OP_REMOVE) || (count_ff == '0)),
      rsp_valid_ff, "short item gave no result")
   `APQ_ASSERT_IMP(a_shift_order, clock, reset, state_ff == S_SHIFT,
      wr_ptr_ff < rd_ptr_ff, "shift pointers crossed")
   `APQ_ASSERT_IMP(a_underflow_empty, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ST_UNDERFLOW),
      count_ff == '0, "underflow with entries held")

endmodule

// ===== sim/tb_array_priority_queue.sv =====
// ----------------------------------------------------------------------------
// tb_array_priority_queue
// Self-checking bench for the array priority queue. Items go in on the
// start/busy handshake and a behavioural queue held in the bench predicts the
// value, status and occupancy of every result. The checker pops the oldest
// prediction on each rsp_valid strobe. The directed tests cover the empty,
// full and tie cases. Random traffic then alternates fill-heavy and
// drain-heavy spells, with random sender gaps and waits for all results.
// ----------------------------------------------------------------------------
module tb_array_priority_queue;
   import apq_pkg::*;

   localparam int QD          = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 40;

   // Unused op code: the queue must leave its state alone
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [STAT_W-1:0]        status;
      logic [OCC_W-1:0]         occupancy;
   } outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [OP_W-1:0]           req_op = OP_INSERT;
   logic signed [DATA_W-1:0]  req_value_in = '0;
   logic signed [DATA_W-1:0]  req_priority_in = '0;
   logic                      rsp_valid;
   logic signed [DATA_W-1:0]  rsp_value_out;
   logic [STAT_W-1:0]         rsp_status;
   logic [OCC_W-1:0]          rsp_occupancy;

   // Bench copy of the queue contents
   logic signed [DATA_W-1:0]  held_values [QD];
   logic signed [DATA_W-1:0]  held_prios [QD];
   int                        held_count = 0;

   outcome_type               expected_outcomes [$];

   int cycle_count    = 0;
   int error_count    = 0;
   int results_seen   = 0;
   int items_sent     = 0;
   int n_insert       = 0;
   int n_overflow     = 0;
   int n_remove       = 0;
   int n_underflow    = 0;
   int n_clear        = 0;
   int n_unused       = 0;
   int peak_count     = 0;
   bit idling_on      = 1'b0;

   array_priority_queue #(
      .QUEUE_DEPTH(QD)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_value_in(req_value_in),
      .req_priority_in(req_priority_in),
      .rsp_valid(rsp_valid),
      .rsp_value_out(rsp_value_out),
      .rsp_status(rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

   // 10 unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_outcomes.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR cycle %0d: %s", cycle_count, what);
   endtask

   // Apply one operation to the bench queue and work out its result
   task automatic queue_step(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
                             input logic signed [DATA_W-1:0] p, output outcome_type o);
      int best;
      o.value  = '0;
      o.status = ST_OK;
      case (op)
         OP_INSERT: begin
            n_insert++;
            if (held_count >= QD) begin
               o.status = ST_OVERFLOW;
               n_overflow++;
            end else begin
               held_values[held_count] = v;
               held_prios[held_count]  = p;
               held_count++;
            end
         end
         OP_REMOVE: begin
            n_remove++;
            if (held_count == 0) begin
               o.status = ST_UNDERFLOW;
               n_underflow++;
            end else begin
               // Strict compare keeps the earliest entry on a tie
               best = 0;
               for (int i = 1; i < held_count; i++)
                  if (held_prios[i] > held_prios[best])
                     best = i;
               o.value = held_values[best];
               for (int i = best; i + 1 < held_count; i++) begin
                  held_values[i] = held_values[i + 1];
                  held_prios[i]  = held_prios[i + 1];
               end
               held_count--;
            end
         end
         OP_CLEAR: begin
            n_clear++;
            held_count = 0;
         end
         default: n_unused++;
      endcase
      if (held_count > peak_count)
         peak_count = held_count;
      o.occupancy = held_count[OCC_W-1:0];
   endtask

   // Present one item and hold it until taken; start stays high afterwards
   task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
                            input logic signed [DATA_W-1:0] p);
      outcome_type o;
      start           <= 1'b1;
      req_op          <= op;
      req_value_in    <= v;
      req_priority_in <= p;
      do @(posedge clock); while (busy !== 1'b0);
      queue_step(op, v, p, o);
      expected_outcomes.push_back(o);
      items_sent++;
   endtask

   // Drop start for a while and put noise on the request fields
   task automatic pause_sender(input int cycles);
      start           <= 1'b0;
      req_op          <= OP_W'($urandom);
      req_value_in    <= $urandom;
      req_priority_in <= $urandom;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold the sender off until every result has come back
   task automatic wait_for_outcomes();
      start <= 1'b0;
      do @(posedge clock); while (expected_outcomes.size() != 0);
   endtask

   task automatic maybe_idle();
      if (idling_on && $urandom_range(0, 5) == 0)
         pause_sender($urandom_range(1, 15));
   endtask

   function automatic logic signed [DATA_W-1:0] pick_priority();
      int r;
      logic signed [DATA_W-1:0] p;
      r = $urandom_range(0, 99);
      if (r < 35) begin
         p = $urandom;
      end else if (r < 70) begin
         // Narrow band so that ties are common
         p = $urandom_range(0, 6);
         p = p - 3;
      end else if (r < 85) begin
         case ($urandom_range(0, 3))
            0: p = MIN_WORD;
            1: p = MAX_WORD;
            2: p = '0;
            default: p = '1;
         endcase
      end else if (r < 93) begin
         p = MAX_WORD - $urandom_range(0, 3);
      end else begin
         p = MIN_WORD + $urandom_range(0, 3);
      end
      return p;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = MIN_WORD;
         1: v = MAX_WORD;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // Compare each strobed result with the oldest prediction
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: value %0d status %0d occ %0d",
                                      rsp_value_out, rsp_status, rsp_occupancy));
         end else begin
            want = expected_outcomes.pop_front();
            results_seen++;
            if (rsp_value_out !== want.value)
               report_mismatch($sformatf("result %0d value %0d, want %0d",
                                         results_seen, rsp_value_out, want.value));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, want %0d",
                                         results_seen, rsp_status, want.status));
            if (rsp_occupancy !== want.occupancy)
               report_mismatch($sformatf("result %0d occupancy %0d, want %0d",
                                         results_seen, rsp_occupancy, want.occupancy));
         end
      end
   end

   // Remove, clear and the unused code on a queue that has never held anything
   task automatic test_empty_queue();
      send_item(OP_REMOVE, 32'sd17, 32'sd5);
      send_item(OP_UNUSED, MAX_WORD, MIN_WORD);
      send_item(OP_CLEAR, '1, '1);
   endtask

   // Field extremes, a tie on the top priority, winner in the middle and last
   task automatic test_extremes();
      send_item(OP_INSERT, MAX_WORD, MIN_WORD);
      send_item(OP_INSERT, MIN_WORD, MAX_WORD);
      send_item(OP_INSERT, '0, '0);
      send_item(OP_INSERT, '1, '1);
      send_item(OP_INSERT, 32'sh5555_aaaa, MAX_WORD);
      send_item(OP_REMOVE, '0, '0);
      send_item(OP_REMOVE, '1, '1);
      send_item(OP_REMOVE, MAX_WORD, MIN_WORD);
   endtask

   // Fill to the brim, overflow, then take the first and a middle winner
   task automatic test_full_queue();
      int prios [QD] = '{9, 1, 4, 1, 5, 9, 2, 6};
      send_item(OP_CLEAR, '0, '0);
      for (int i = 0; i < QD; i++)
         send_item(OP_INSERT, 100 + i, prios[i]);
      send_item(OP_INSERT, 32'sd999, MAX_WORD);
      send_item(OP_UNUSED, 32'sd1, 32'sd1);
      send_item(OP_REMOVE, '0, '0);
      send_item(OP_REMOVE, '0, '0);
   endtask

   // Let every outstanding result come back, then carry on
   task automatic test_drain_pause();
      for (int i = 0; i < 6; i++)
         send_item(OP_INSERT, pick_value(), pick_priority());
      wait_for_outcomes();
      send_item(OP_REMOVE, '0, '0);
      wait_for_outcomes();
   endtask

   // Random traffic in fill-heavy and drain-heavy spells
   task automatic test_random_traffic(input int count);
      bit filling;
      int r;
      logic [OP_W-1:0] op;
      filling = 1'b1;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 29) == 0)
            filling = !filling;
         r = $urandom_range(0, 99);
         if (r < (filling ? 65 : 40))
            op = OP_INSERT;
         else if (r < 95)
            op = OP_REMOVE;
         else if (r < 98)
            op = OP_CLEAR;
         else
            op = OP_UNUSED;
         send_item(op, pick_value(), pick_priority());
         if (idling_on && n % 250 == 249)
            wait_for_outcomes();
         else
            maybe_idle();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_extremes();
      test_full_queue();
      idling_on = 1'b1;
      test_drain_pause();
      test_random_traffic(1400);
      // Back-to-back stream to finish
      idling_on = 1'b0;
      test_random_traffic(200);

      wait_for_outcomes();
      repeat (2 * QD + 4) @(posedge clock);
      if (expected_outcomes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));

      $display("Sent %0d items: %0d inserts (%0d overflow), %0d removes (%0d underflow),",
               items_sent, n_insert, n_overflow, n_remove, n_underflow);
      $display("%0d clears, %0d unused codes; %0d results checked, peak occupancy %0d",
               n_clear, n_unused, results_seen, peak_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", error_count);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
